[design/smwm_pkg.sv]
// ----------------------------------------------------------------------------
// smwm_pkg
// Shared types and codes for the stack with middle access.
// ----------------------------------------------------------------------------
package smwm_pkg;

  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int WORD_W   = 32;
  localparam int COUNT_W  = 9;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DEL  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic accept;
    logic update;
    logic finish;
  } phase_t;

endpackage

[design/smwm_ram.sv]
// ----------------------------------------------------------------------------
// smwm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/smwm_ctrl.sv]
// ----------------------------------------------------------------------------
// smwm_ctrl
// Sequencer: accept, read-modify-write phase, release and result phase.
// ----------------------------------------------------------------------------
module smwm_ctrl
  import smwm_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  output logic   busy_o,
  output phase_t phase_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (start_i) state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_FINISH;
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy_o         = 1'b1;
    phase_o        = '0;
    case (state_q)
      ST_IDLE: begin
        busy_o         = 1'b0;
        phase_o.accept = start_i;
      end
      ST_UPDATE: phase_o.update = 1'b1;
      ST_FINISH: phase_o.finish = 1'b1;
      default:   busy_o = 1'b1;
    endcase
  end

endmodule

[design/stack_with_middle_access.sv]
// An item is accepted while busy_o is low; its result strobe follows its update
// and finish phases, and busy_o is low again in the cycle of that strobe.
// A new item is not accepted until the read, rewrite and release passes over
// the slot and link memories for the last one are through.
// Reset clears pointers, counts and free list; memories are not cleared.
// The receiver cannot stall: done_o is high for exactly one cycle per item.
// ----------------------------------------------------------------------------
// stack_with_middle_access
// Bounded stack held as a doubly linked list in slot RAMs, with a tracked
// middle pointer; push, pop top and delete middle.
// ----------------------------------------------------------------------------
module stack_with_middle_access
  import smwm_pkg::*;
#(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic        [KIND_W-1:0]   kind_i,
  input  logic signed [WORD_W-1:0]   push_value_i,
  output logic                       done_o,
  output logic        [STATUS_W-1:0] status_o,
  output logic signed [WORD_W-1:0]   removed_value_o,
  output logic signed [WORD_W-1:0]   middle_value_o,
  output logic        [COUNT_W-1:0]  count_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  phase_t ph;

  smwm_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .phase_o (ph)
  );

  // control state
  logic [AW-1:0] top_q, top_d;
  logic [AW-1:0] mid_q, mid_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] fhead_q, fhead_d;
  logic [CW-1:0] flen_q, flen_d;
  logic [CW-1:0] fresh_q, fresh_d;
  logic          act_push_q, act_pop_q, act_del_q;
  logic [STATUS_W-1:0] status_q;
  logic          done_q;

  // payload
  logic signed [DATA_WIDTH-1:0] pv_q;
  logic signed [DATA_WIDTH-1:0] removed_q;
  logic [AW-1:0]                slot_q;
  logic                         fwd_q;
  logic [STATUS_W-1:0]          status_out_q;
  logic signed [WORD_W-1:0]     removed_out_q;
  logic signed [WORD_W-1:0]     middle_out_q;
  logic [COUNT_W-1:0]           count_out_q;

  // memory ports
  logic                  val_we, dn_we, up_we;
  logic [AW-1:0]         val_waddr, dn_waddr, up_waddr;
  logic [DATA_WIDTH-1:0] val_wdata, val_rdata;
  logic [AW-1:0]         dn_wdata, up_wdata;
  logic [AW-1:0]         val_raddr, dna_raddr, dnb_raddr, up_raddr;
  logic [AW-1:0]         dna_rdata, dnb_rdata, up_rdata;

  logic empty, full, one, odd, many;
  assign empty = (cnt_q == '0);
  assign full  = (cnt_q == CW'(DEPTH));
  assign one   = (cnt_q == CW'(1));
  assign odd   = cnt_q[0];
  assign many  = (cnt_q > CW'(2));

  // accept-cycle decode
  logic                a_push, a_pop, a_del;
  logic [STATUS_W-1:0] a_status;
  logic [AW-1:0]       a_slot;

  always_comb begin
    a_push   = 1'b0;
    a_pop    = 1'b0;
    a_del    = 1'b0;
    a_status = STATUS_DONE;
    a_slot   = mid_q;
    case (kind_i)
      KIND_PUSH: begin
        if (full) a_status = STATUS_FULL;
        else a_push = 1'b1;
        a_slot = (flen_q != '0) ? fhead_q : fresh_q[AW-1:0];
      end
      KIND_POP: begin
        if (empty) a_status = STATUS_EMPTY;
        else a_pop = 1'b1;
        a_slot = top_q;
      end
      KIND_DEL: begin
        if (empty) a_status = STATUS_EMPTY;
        else a_del = 1'b1;
        a_slot = mid_q;
      end
      default: a_status = STATUS_DONE;
    endcase
  end

  // reads issued in the accept cycle; data arrives in the update phase
  assign dnb_raddr = mid_q;
  assign up_raddr  = mid_q;

  always_comb begin
    case (kind_i)
      KIND_PUSH: dna_raddr = fhead_q;
      KIND_POP:  dna_raddr = top_q;
      default:   dna_raddr = mid_q;
    endcase
  end

  assign val_raddr = ph.update ? mid_d : ((kind_i == KIND_POP) ? top_q : mid_q);

  // update phase: relink, take slot, move pointers; finish: release slot
  always_comb begin
    top_d     = top_q;
    mid_d     = mid_q;
    cnt_d     = cnt_q;
    fhead_d   = fhead_q;
    flen_d    = flen_q;
    fresh_d   = fresh_q;
    val_we    = 1'b0;
    val_waddr = slot_q;
    val_wdata = pv_q;
    dn_we     = 1'b0;
    dn_waddr  = slot_q;
    dn_wdata  = top_q;
    up_we     = 1'b0;
    up_waddr  = top_q;
    up_wdata  = slot_q;
    if (ph.update) begin
      if (act_push_q) begin
        val_we = 1'b1;
        top_d  = slot_q;
        cnt_d  = cnt_q + CW'(1);
        if (flen_q != '0) begin
          fhead_d = dna_rdata;
          flen_d  = flen_q - CW'(1);
        end else begin
          fresh_d = fresh_q + CW'(1);
        end
        if (empty) begin
          mid_d = slot_q;
        end else begin
          dn_we = 1'b1;
          up_we = 1'b1;
          if (!odd) mid_d = up_rdata;
        end
      end else if (act_pop_q) begin
        cnt_d = cnt_q - CW'(1);
        if (one) begin
          top_d = '0;
          mid_d = '0;
        end else begin
          top_d = dna_rdata;
          if (odd) mid_d = dnb_rdata;
        end
      end else if (act_del_q) begin
        cnt_d = cnt_q - CW'(1);
        if (one) begin
          top_d = '0;
          mid_d = '0;
        end else begin
          mid_d = odd ? dna_rdata : up_rdata;
        end
        // unlink middle: below.up = above, above.down = below
        if (many) begin
          dn_we    = 1'b1;
          dn_waddr = up_rdata;
          dn_wdata = dna_rdata;
          up_we    = 1'b1;
          up_waddr = dna_rdata;
          up_wdata = up_rdata;
        end
      end
    end else if (ph.finish && (act_pop_q || act_del_q)) begin
      // released slot goes to the head of the free list
      dn_we    = 1'b1;
      dn_waddr = slot_q;
      dn_wdata = fhead_q;
      fhead_d  = slot_q;
      flen_d   = flen_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q      <= '0;
      mid_q      <= '0;
      cnt_q      <= '0;
      fhead_q    <= '0;
      flen_q     <= '0;
      fresh_q    <= '0;
      act_push_q <= 1'b0;
      act_pop_q  <= 1'b0;
      act_del_q  <= 1'b0;
      status_q   <= STATUS_DONE;
      done_q     <= 1'b0;
    end else begin
      top_q   <= top_d;
      mid_q   <= mid_d;
      cnt_q   <= cnt_d;
      fhead_q <= fhead_d;
      flen_q  <= flen_d;
      fresh_q <= fresh_d;
      done_q  <= ph.finish;
      if (ph.accept) begin
        act_push_q <= a_push;
        act_pop_q  <= a_pop;
        act_del_q  <= a_del;
        status_q   <= a_status;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ph.accept) begin
      pv_q   <= DATA_WIDTH'(push_value_i);
      slot_q <= a_slot;
    end
    if (ph.update) begin
      removed_q <= (act_pop_q || act_del_q) ? val_rdata : '0;
      // first push writes the slot that is read back as the middle
      fwd_q     <= act_push_q && empty;
    end
    if (ph.finish) begin
      status_out_q  <= status_q;
      removed_out_q <= WORD_W'(removed_q);
      count_out_q   <= COUNT_W'(cnt_q);
      if (empty) middle_out_q <= '1;
      else if (fwd_q) middle_out_q <= WORD_W'(pv_q);
      else middle_out_q <= WORD_W'($signed(val_rdata));
    end
  end

  smwm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata)
  );

  // two copies of the downward links give two reads per cycle
  smwm_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_dna_ram (
    .clk_i   (clk_i),
    .we_i    (dn_we),
    .waddr_i (dn_waddr),
    .wdata_i (dn_wdata),
    .raddr_i (dna_raddr),
    .rdata_o (dna_rdata)
  );

  smwm_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_dnb_ram (
    .clk_i   (clk_i),
    .we_i    (dn_we),
    .waddr_i (dn_waddr),
    .wdata_i (dn_wdata),
    .raddr_i (dnb_raddr),
    .rdata_o (dnb_rdata)
  );

  smwm_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_up_ram (
    .clk_i   (clk_i),
    .we_i    (up_we),
    .waddr_i (up_waddr),
    .wdata_i (up_wdata),
    .raddr_i (up_raddr),
    .rdata_o (up_rdata)
  );

  assign done_o          = done_q;
  assign status_o        = status_out_q;
  assign removed_value_o = removed_out_q;
  assign middle_value_o  = middle_out_q;
  assign count_o         = count_out_q;

endmodule

[dv/stack_with_middle_access_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_with_middle_access_tb
// Self-checking bench for the stack with middle access. A directed table
// covers empty, single-element and extreme-value cases. Random phases then
// fill the stack to its limit, drain it past empty and mix all operations.
// Results are compared with a queue-based model, or with the row's own for typed rows.
// ----------------------------------------------------------------------------
module stack_with_middle_access_tb;
  import smwm_pkg::*;

  localparam int STACK_DEPTH  = 256;
  localparam int RANDOM_ITEMS = 800;
  localparam int CYCLE_LIMIT  = 300000;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   removed;
    logic [WORD_W-1:0]   middle;
    logic [COUNT_W-1:0]  count;
  } result_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] value;
    logic              typed;
    result_t           want;
  } step_row_t;

  localparam int DIRECTED_ROWS = 22;

  // typed rows carry their result, the rest go through the stack model
  step_row_t directed_rows [DIRECTED_ROWS] = '{
    '{KIND_POP,    32'h0000_0000, 1'b1, '{STATUS_EMPTY, 32'h0, 32'hFFFF_FFFF, 9'd0}},
    '{KIND_DEL,    32'h1234_5678, 1'b1, '{STATUS_EMPTY, 32'h0, 32'hFFFF_FFFF, 9'd0}},
    '{KIND_UNUSED, 32'hA5A5_A5A5, 1'b1, '{STATUS_DONE,  32'h0, 32'hFFFF_FFFF, 9'd0}},
    '{KIND_PUSH,   32'h7FFF_FFFF, 1'b1, '{STATUS_DONE,  32'h0, 32'h7FFF_FFFF, 9'd1}},
    '{KIND_DEL,    32'h0000_0000, 1'b1,
      '{STATUS_DONE, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 9'd0}},
    '{KIND_PUSH,   32'h8000_0000, 1'b1, '{STATUS_DONE,  32'h0, 32'h8000_0000, 9'd1}},
    '{KIND_POP,    32'h0000_0000, 1'b1,
      '{STATUS_DONE, 32'h8000_0000, 32'hFFFF_FFFF, 9'd0}},
    '{KIND_PUSH,   32'h7FFF_FFFF, 1'b0, '0},
    '{KIND_PUSH,   32'h8000_0000, 1'b0, '0},
    '{KIND_PUSH,   32'h0000_0000, 1'b0, '0},
    '{KIND_PUSH,   32'hFFFF_FFFF, 1'b0, '0},
    '{KIND_PUSH,   32'h0000_0001, 1'b0, '0},
    '{KIND_DEL,    32'h0000_0000, 1'b0, '0},
    '{KIND_DEL,    32'h0000_0000, 1'b0, '0},
    '{KIND_UNUSED, 32'hFFFF_FFFF, 1'b0, '0},
    '{KIND_POP,    32'hFFFF_FFFF, 1'b0, '0},
    '{KIND_DEL,    32'h0000_0000, 1'b0, '0},
    '{KIND_PUSH,   32'h5555_5555, 1'b0, '0},
    '{KIND_PUSH,   32'hAAAA_AAAA, 1'b0, '0},
    '{KIND_POP,    32'h0000_0000, 1'b0, '0},
    '{KIND_POP,    32'h0000_0000, 1'b0, '0},
    '{KIND_DEL,    32'h0000_0000, 1'b0, '0}
  };

  logic                clk_i;
  logic                rst_ni       = 1'b0;
  logic                start_i      = 1'b0;
  logic [KIND_W-1:0]   kind_i       = KIND_PUSH;
  logic [WORD_W-1:0]   push_value_i = '0;
  logic                busy_o;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [WORD_W-1:0]   removed_value_o;
  logic [WORD_W-1:0]   middle_value_o;
  logic [COUNT_W-1:0]  count_o;

  stack_with_middle_access #(
    .DEPTH      (STACK_DEPTH),
    .DATA_WIDTH (WORD_W)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .kind_i          (kind_i),
    .push_value_i    (push_value_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .removed_value_o (removed_value_o),
    .middle_value_o  (middle_value_o),
    .count_o         (count_o)
  );

  // bottom of the stack at index 0
  logic [WORD_W-1:0] stack_words [$];
  result_t           pending_results [$];

  int mismatches   = 0;
  int random_items = 0;
  int quiet_left   = 0;
  int cycles       = 0;
  int n_push       = 0;
  int n_pop        = 0;
  int n_del        = 0;
  int n_ignored    = 0;
  int n_full       = 0;
  int n_empty      = 0;
  int peak_depth   = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t ns: no progress within %0d cycles", $time, CYCLE_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  task automatic apply_stack_op(input logic [KIND_W-1:0] kind,
                                input logic [WORD_W-1:0] value,
                                output result_t res);
    int depth_now;
    depth_now = stack_words.size();
    res = '0;
    case (kind)
      KIND_PUSH: begin
        if (depth_now >= STACK_DEPTH) begin
          res.status = STATUS_FULL;
          n_full++;
        end else begin
          stack_words.push_back(value);
          n_push++;
        end
      end
      KIND_POP: begin
        if (depth_now == 0) begin
          res.status = STATUS_EMPTY;
          n_empty++;
        end else begin
          res.removed = stack_words.pop_back();
          n_pop++;
        end
      end
      KIND_DEL: begin
        if (depth_now == 0) begin
          res.status = STATUS_EMPTY;
          n_empty++;
        end else begin
          res.removed = stack_words[(depth_now + 1) / 2 - 1];
          stack_words.delete((depth_now + 1) / 2 - 1);
          n_del++;
        end
      end
      default: n_ignored++;
    endcase
    depth_now = stack_words.size();
    res.middle = (depth_now == 0) ? '1 : stack_words[(depth_now + 1) / 2 - 1];
    res.count  = COUNT_W'(depth_now);
    if (depth_now > peak_depth) peak_depth = depth_now;
  endtask

  // mostly back to back or short gaps, now and then a long one or a quiet run
  function automatic int pick_gap();
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      quiet_left = $urandom_range(20, 50);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic issue_op(input logic [KIND_W-1:0] kind,
                          input logic [WORD_W-1:0] value,
                          input logic typed,
                          input result_t want);
    result_t model;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    kind_i       <= kind;
    push_value_i <= value;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    apply_stack_op(kind, value, model);
    pending_results.push_back(typed ? want : model);
  endtask

  task automatic random_op(input int push_pct);
    logic [KIND_W-1:0] kind;
    int r;
    r = $urandom_range(0, 99);
    if (r < 3)                  kind = KIND_UNUSED;
    else if (r < 3 + push_pct)  kind = KIND_PUSH;
    else if ($urandom_range(0, 1)) kind = KIND_POP;
    else                        kind = KIND_DEL;
    if (kind != KIND_UNUSED) random_items++;
    issue_op(kind, pick_word(), 1'b0, '0);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic report_field(input string field,
                              input logic signed [63:0] want,
                              input logic signed [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t ns: result strobe with no item outstanding", $time);
      end else begin
        want = pending_results.pop_front();
        report_field("status", want.status, status_o);
        report_field("removed_value", $signed(want.removed), $signed(removed_value_o));
        report_field("middle_value", $signed(want.middle), $signed(middle_value_o));
        report_field("count", want.count, count_o);
      end
    end
  end

  initial begin
    int row;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (row = 0; row < DIRECTED_ROWS; row++) begin
      issue_op(directed_rows[row].kind, directed_rows[row].value,
               directed_rows[row].typed, directed_rows[row].want);
    end

    repeat (150) random_op(50);

    // fill to the limit, then work the full boundary
    while (stack_words.size() < STACK_DEPTH) random_op(85);
    issue_op(KIND_PUSH, pick_word(), 1'b0, '0);
    issue_op(KIND_PUSH, pick_word(), 1'b0, '0);
    issue_op(KIND_DEL,  pick_word(), 1'b0, '0);
    issue_op(KIND_PUSH, pick_word(), 1'b0, '0);
    issue_op(KIND_PUSH, pick_word(), 1'b0, '0);
    issue_op(KIND_POP,  pick_word(), 1'b0, '0);
    issue_op(KIND_PUSH, pick_word(), 1'b0, '0);

    // hold off until every outstanding item has reported
    start_i <= 1'b0;
    wait_drained();

    // drain past empty
    while (stack_words.size() > 0) random_op(10);
    issue_op(KIND_POP, pick_word(), 1'b0, '0);
    issue_op(KIND_DEL, pick_word(), 1'b0, '0);
    issue_op(KIND_DEL, pick_word(), 1'b0, '0);
    issue_op(KIND_POP, pick_word(), 1'b0, '0);

    while (random_items < RANDOM_ITEMS) random_op($urandom_range(35, 65));

    start_i <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("covered %0d pushes, %0d pops, %0d middle deletes, %0d unused-kind items",
             n_push, n_pop, n_del, n_ignored);
    $display("refused %0d pushes when full, %0d removals when empty; deepest stack %0d",
             n_full, n_empty, peak_depth);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule
